>>> rtl/core/bop_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and name tables for the boot option parser.
package bop_pkg;

  localparam logic [7:0] END_CHAR   = 8'h00;
  localparam logic [7:0] SP_CHAR    = 8'h20;
  localparam logic [7:0] TAB_CHAR   = 8'h09;
  localparam logic [7:0] CR_CHAR    = 8'h0D;
  localparam logic [7:0] BS_CHAR    = 8'h5C;
  localparam logic [7:0] EQ_CHAR    = 8'h3D;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] MINUS_CHAR = 8'h2D;
  localparam logic [7:0] X_LO_CHAR  = 8'h78;
  localparam logic [7:0] X_UP_CHAR  = 8'h58;

  localparam logic [4:0] PORT_LEN  = 5'd9;
  localparam logic [4:0] SPEED_LEN = 5'd10;
  localparam logic [4:0] POS_MAX   = 5'd31;

  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 2;
  localparam int OUT_VALUE_W = 32;

  typedef struct packed {
    logic [7:0] code;
    logic       is_end;
    logic       is_blank;
    logic       is_ws;
    logic       is_bs;
    logic       is_eq;
    logic       is_plus;
    logic       is_minus;
    logic       is_x;
    logic       digit_ok;
    logic [3:0] digit;
  } char_class_t;

  typedef struct packed {
    logic                   option_id;
    logic [OUT_VALUE_W-1:0] option_value;
  } result_t;

  function automatic logic [7:0] port_char(input logic [4:0] pos);
    logic [7:0] ch;
    case (pos)
      5'd0: ch = "d";
      5'd1: ch = "e";
      5'd2: ch = "b";
      5'd3: ch = "u";
      5'd4: ch = "g";
      5'd5: ch = "p";
      5'd6: ch = "o";
      5'd7: ch = "r";
      5'd8: ch = "t";
      default: ch = END_CHAR;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] speed_char(input logic [4:0] pos);
    logic [7:0] ch;
    case (pos)
      5'd0: ch = "d";
      5'd1: ch = "e";
      5'd2: ch = "b";
      5'd3: ch = "u";
      5'd4: ch = "g";
      5'd5: ch = "s";
      5'd6: ch = "p";
      5'd7: ch = "e";
      5'd8: ch = "e";
      5'd9: ch = "d";
      default: ch = END_CHAR;
    endcase
    return ch;
  endfunction

endpackage

>>> rtl/core/bop_fifo.sv
`timescale 1ns / 1ps
// Small register-based queue used between the parser stages and in front of the result ports.
module bop_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/core/bop_front.sv
`timescale 1ns / 1ps
// Front stage: classifies each incoming character for the parser back end.
module bop_front (
  input  logic [7:0]           char_code_i,
  output bop_pkg::char_class_t class_o
);
  import bop_pkg::*;

  always_comb begin
    class_o          = '0;
    class_o.code     = char_code_i;
    class_o.is_end   = (char_code_i == END_CHAR);
    class_o.is_blank = (char_code_i == SP_CHAR);
    class_o.is_ws    = (char_code_i == SP_CHAR) ||
                       (char_code_i >= TAB_CHAR && char_code_i <= CR_CHAR);
    class_o.is_bs    = (char_code_i == BS_CHAR);
    class_o.is_eq    = (char_code_i == EQ_CHAR);
    class_o.is_plus  = (char_code_i == PLUS_CHAR);
    class_o.is_minus = (char_code_i == MINUS_CHAR);
    class_o.is_x     = (char_code_i == X_LO_CHAR) || (char_code_i == X_UP_CHAR);
    if (char_code_i >= "0" && char_code_i <= "9") begin
      class_o.digit_ok = 1'b1;
      class_o.digit    = 4'(char_code_i - "0");
    end else if (char_code_i >= "a" && char_code_i <= "f") begin
      class_o.digit_ok = 1'b1;
      class_o.digit    = 4'(char_code_i - "a" + 8'd10);
    end else if (char_code_i >= "A" && char_code_i <= "F") begin
      class_o.digit_ok = 1'b1;
      class_o.digit    = 4'(char_code_i - "A" + 8'd10);
    end
  end

endmodule

>>> rtl/core/bop_back.sv
`timescale 1ns / 1ps
// Back stage: parse state machine, name matching and value conversion.
module bop_back #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  bop_pkg::char_class_t in_class_i,
  output logic                 in_pop_o,
  input  logic                 out_full_i,
  output logic                 out_push_o,
  output bop_pkg::result_t     out_result_o
);
  import bop_pkg::*;

  typedef enum logic [2:0] {
    PH_IMAGE, PH_BLANK, PH_AT_BS, PH_NAME, PH_VALUE
  } phase_e;

  typedef enum logic [2:0] {
    NP_SKIP, NP_SIGNED, NP_ZERO, NP_PREFIX, NP_DIGITS, NP_STOP
  } num_e;

  typedef enum logic [1:0] {
    BASE_DEC, BASE_OCT, BASE_HEX
  } base_e;

  localparam int ProdW = VALUE_WIDTH + 4;

  phase_e                 phase_q, phase_d;
  logic [4:0]             pos_q, pos_d;
  logic [1:0]             flags_q, flags_d, flags_eq;
  logic                   started_q, started_d;
  num_e                   num_q, num_d;
  base_e                  base_q, base_d;
  logic                   neg_q, neg_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d, emit_value;
  logic                   ovf_q, ovf_d;
  logic [ProdW-1:0]       acc_ext, prod;
  logic                   prod_ovf, digit_in, do_take, fire, emit, match_one, is_close;
  char_class_t            ch;

  assign ch        = in_class_i;
  assign fire      = in_valid_i && !out_full_i;
  assign in_pop_o  = fire;
  assign match_one = (flags_q == 2'b01) || (flags_q == 2'b10);
  assign is_close  = ch.is_blank || ch.is_bs;
  assign acc_ext   = ProdW'(acc_q);

  always_comb begin
    case (base_q)
      BASE_HEX: prod = (acc_ext << 4) + ProdW'(ch.digit);
      BASE_OCT: prod = (acc_ext << 3) + ProdW'(ch.digit);
      default:  prod = (acc_ext << 3) + (acc_ext << 1) + ProdW'(ch.digit);
    endcase
    prod_ovf = (prod[ProdW-1:VALUE_WIDTH] != '0);
    case (base_q)
      BASE_HEX: digit_in = ch.digit_ok;
      BASE_OCT: digit_in = ch.digit_ok && (ch.digit < 4'd8);
      default:  digit_in = ch.digit_ok && (ch.digit < 4'd10);
    endcase
  end

  always_comb begin
    if (ovf_q) begin
      emit_value = '1;
    end else if (neg_q) begin
      emit_value = '0 - acc_q;
    end else begin
      emit_value = acc_q;
    end
    out_result_o.option_id    = (flags_q == 2'b10);
    out_result_o.option_value = OUT_VALUE_W'(emit_value);
  end

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    flags_d   = flags_q;
    started_d = started_q;
    num_d     = num_q;
    base_d    = base_q;
    neg_d     = neg_q;
    acc_d     = acc_q;
    ovf_d     = ovf_q;
    emit      = 1'b0;
    do_take   = 1'b0;
    flags_eq  = flags_q;
    if (pos_q != PORT_LEN) begin
      flags_eq[0] = 1'b0;
    end
    if (pos_q != SPEED_LEN) begin
      flags_eq[1] = 1'b0;
    end
    if (fire) begin
      if (ch.is_end) begin
        emit      = (phase_q == PH_VALUE) && started_q && match_one;
        phase_d   = PH_IMAGE;
        pos_d     = '0;
        flags_d   = 2'b11;
        started_d = 1'b0;
        num_d     = NP_SKIP;
        base_d    = BASE_DEC;
        neg_d     = 1'b0;
        acc_d     = '0;
        ovf_d     = 1'b0;
      end else begin
        unique case (phase_q) inside
          PH_BLANK, PH_AT_BS: begin
            if (ch.is_bs) begin
              phase_d = PH_NAME;
              pos_d   = '0;
              flags_d = 2'b11;
            end else if (!ch.is_blank) begin
              phase_d = PH_AT_BS;
            end else begin
              phase_d = PH_BLANK;
            end
          end
          PH_NAME: begin
            if (ch.is_eq) begin
              flags_d   = flags_eq;
              phase_d   = PH_VALUE;
              started_d = 1'b0;
              num_d     = NP_SKIP;
              base_d    = (flags_eq == 2'b01) ? BASE_HEX : BASE_DEC;
              neg_d     = 1'b0;
              acc_d     = '0;
              ovf_d     = 1'b0;
            end else if (ch.is_blank) begin
              phase_d = PH_BLANK;
            end else begin
              if (!(pos_q < PORT_LEN && ch.code == port_char(pos_q))) begin
                flags_d[0] = 1'b0;
              end
              if (!(pos_q < SPEED_LEN && ch.code == speed_char(pos_q))) begin
                flags_d[1] = 1'b0;
              end
              if (pos_q < POS_MAX) begin
                pos_d = pos_q + 1'b1;
              end
            end
          end
          PH_VALUE: begin
            if (started_q && is_close) begin
              emit = match_one;
              if (ch.is_blank) begin
                phase_d = PH_BLANK;
              end else begin
                phase_d = PH_NAME;
                pos_d   = '0;
                flags_d = 2'b11;
              end
            end else begin
              started_d = 1'b1;
              case (num_q) inside
                NP_SKIP, NP_SIGNED: begin
                  if (num_q == NP_SKIP && ch.is_ws) begin
                    num_d = NP_SKIP;
                  end else if (num_q == NP_SKIP && ch.is_plus) begin
                    num_d = NP_SIGNED;
                  end else if (num_q == NP_SKIP && ch.is_minus) begin
                    neg_d = 1'b1;
                    num_d = NP_SIGNED;
                  end else if (ch.digit_ok && ch.digit == 4'd0) begin
                    if (flags_q != 2'b01) begin
                      base_d = BASE_OCT;
                    end
                    num_d = NP_ZERO;
                  end else if (digit_in) begin
                    do_take = 1'b1;
                    num_d   = NP_DIGITS;
                  end else begin
                    num_d = NP_STOP;
                  end
                end
                NP_ZERO: begin
                  if (ch.is_x) begin
                    base_d = BASE_HEX;
                    num_d  = NP_PREFIX;
                  end else if (digit_in) begin
                    do_take = 1'b1;
                    num_d   = NP_DIGITS;
                  end else begin
                    num_d = NP_STOP;
                  end
                end
                NP_PREFIX, NP_DIGITS: begin
                  if (digit_in) begin
                    do_take = 1'b1;
                    num_d   = NP_DIGITS;
                  end else begin
                    num_d = NP_STOP;
                  end
                end
                default: begin
                  num_d = num_q;
                end
              endcase
            end
          end
          default: begin
            if (ch.is_blank) begin
              phase_d = PH_BLANK;
            end else if (ch.is_bs) begin
              phase_d = PH_NAME;
              pos_d   = '0;
              flags_d = 2'b11;
            end else begin
              phase_d = PH_IMAGE;
            end
          end
        endcase
        if (do_take && !ovf_q) begin
          if (prod_ovf) begin
            ovf_d = 1'b1;
          end else begin
            acc_d = prod[VALUE_WIDTH-1:0];
          end
        end
      end
    end
  end

  assign out_push_o = emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IMAGE;
      pos_q     <= '0;
      flags_q   <= 2'b11;
      started_q <= 1'b0;
      num_q     <= NP_SKIP;
      base_q    <= BASE_DEC;
      neg_q     <= 1'b0;
      acc_q     <= '0;
      ovf_q     <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      flags_q   <= flags_d;
      started_q <= started_d;
      num_q     <= num_d;
      base_q    <= base_d;
      neg_q     <= neg_d;
      acc_q     <= acc_d;
      ovf_q     <= ovf_d;
    end
  end

endmodule

>>> rtl/core/boot_option_parser.sv
`timescale 1ns / 1ps
// Top level of the boot option parser: classifier, queues and parse engine.
//
//   Channel  | Handshake         | Fields
//   ---------+-------------------+---------------------------------
//   input    | push / full       | char_code_i[7:0]
//   result   | empty / pop       | option_id_o, option_value_o[31:0]
//
// One character is taken every cycle unless the input queue is full; the
// parse engine retires one item per cycle unless the result queue is full,
// through its single shift-and-add accumulator. A result shows on the result
// ports after the engine takes its closing character and pushes the result.
// Reset clears both queues and the parse state at once; no sweep follows.
// A full result queue stalls the engine, which then fills the input queue.
module boot_option_parser #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_code_i,
  output logic        empty,
  input  logic        pop,
  output logic        option_id_o,
  output logic [31:0] option_value_o
);
  import bop_pkg::*;

  char_class_t front_class, mid_class;
  result_t     back_result, out_result;
  logic        mid_empty, mid_pop, out_full, out_push;

  bop_front u_front (
    .char_code_i (char_code_i),
    .class_o     (front_class)
  );

  bop_fifo #(
    .WIDTH ($bits(char_class_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_class),
    .full_o  (full),
    .pop_i   (mid_pop),
    .data_o  (mid_class),
    .empty_o (mid_empty)
  );

  bop_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (!mid_empty),
    .in_class_i   (mid_class),
    .in_pop_o     (mid_pop),
    .out_full_i   (out_full),
    .out_push_o   (out_push),
    .out_result_o (back_result)
  );

  bop_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (back_result),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_result),
    .empty_o (empty)
  );

  assign option_id_o    = out_result.option_id;
  assign option_value_o = out_result.option_value;

endmodule

>>> rtl/core/bop_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the boot option parser and their bind to the top level.
module bop_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic        option_id_o,
  input logic [31:0] option_value_o
);

  a_reset_clear: assert property (@(posedge clk_i) !rst_ni |-> empty && !full)
    else $error("Queues are not clear during reset.");

  a_full_needs_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(full) && !$past(push) |-> !full)
    else $error("Input queue became full without an accepted item.");

  a_empty_needs_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(empty) |-> $past(pop))
    else $error("Result queue drained without a pop.");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(option_id_o) && $stable(option_value_o))
    else $error("Waiting result item changed while stalled.");

endmodule

bind boot_option_parser bop_checker u_bop_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .push           (push),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .option_id_o    (option_id_o),
  .option_value_o (option_value_o)
);

>>> bench/tb_boot_option_parser.sv
`timescale 1ns / 1ps
// Self-checking testbench for the boot option parser with directed and random command lines.
module tb_boot_option_parser;
  import bop_pkg::*;

  typedef enum logic [2:0] {LINE_IMAGE, LINE_BLANK, LINE_AT_BS, LINE_NAME, LINE_VALUE} line_phase_e;
  typedef enum logic [2:0] {
    NUM_SKIP, NUM_SIGNED, NUM_ZERO, NUM_PREFIX, NUM_DIGITS, NUM_STOP
  } num_phase_e;
  typedef enum logic [1:0] {RADIX_DEC, RADIX_OCT, RADIX_HEX} radix_e;

  localparam logic [1:0]  HITS_PORT   = 2'b01;
  localparam logic [1:0]  HITS_SPEED  = 2'b10;
  localparam logic [1:0]  HITS_BOTH   = 2'b11;
  localparam logic        PORT_ID     = 1'b0;
  localparam logic        SPEED_ID    = 1'b1;
  localparam logic [63:0] ALL_ONES    = 64'h0000_0000_FFFF_FFFF;
  localparam int unsigned NO_DIGIT    = 99;
  localparam int unsigned MAX_WAIT    = 15;
  localparam int unsigned ITEM_TARGET = 1230;
  localparam int unsigned SETTLE      = 20;
  localparam int unsigned CYCLE_LIMIT = 300000;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  char_code_i;
  logic        empty;
  logic        pop;
  logic        option_id_o;
  logic [31:0] option_value_o;

  boot_option_parser u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .char_code_i    (char_code_i),
    .empty          (empty),
    .pop            (pop),
    .option_id_o    (option_id_o),
    .option_value_o (option_value_o)
  );

  string       port_word  = "debugport";
  string       speed_word = "debugspeed";

  line_phase_e line_phase;
  logic [4:0]  name_pos;
  logic [1:0]  name_hits;
  logic        value_begun;
  num_phase_e  num_phase;
  radix_e      num_radix;
  logic        negative;
  logic [63:0] accum;
  logic        overflowed;

  result_t     pending_options[$];
  int unsigned items_sent;
  int unsigned cycle_count;
  int          errors;
  bit          send_calm;
  bit          pop_calm;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Parser prediction.
  function automatic int unsigned radix_value(input radix_e r);
    if (r == RADIX_HEX) return 16;
    if (r == RADIX_OCT) return 8;
    return 10;
  endfunction

  function automatic int unsigned digit_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return 32'(c) - 32'h30;
    if (c >= 8'h61 && c <= 8'h66) return 32'(c) - 32'h61 + 32'd10;
    if (c >= 8'h41 && c <= 8'h46) return 32'(c) - 32'h41 + 32'd10;
    return NO_DIGIT;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == SP_CHAR || (c >= TAB_CHAR && c <= CR_CHAR);
  endfunction

  task automatic reset_parser();
    line_phase  = LINE_IMAGE;
    name_pos    = '0;
    name_hits   = HITS_BOTH;
    value_begun = 1'b0;
    num_phase   = NUM_SKIP;
    num_radix   = RADIX_DEC;
    negative    = 1'b0;
    accum       = '0;
    overflowed  = 1'b0;
  endtask

  task automatic take_digit(input int unsigned d);
    logic [63:0] r;
    r = 64'(radix_value(num_radix));
    if (!overflowed) begin
      if (accum > (ALL_ONES - 64'(d)) / r) overflowed = 1'b1;
      else accum = accum * r + 64'(d);
    end
  endtask

  task automatic first_digit(input logic [7:0] c);
    int unsigned d;
    d = digit_value(c);
    if (c == 8'h30) begin
      if (name_hits != HITS_PORT) num_radix = RADIX_OCT;
      num_phase = NUM_ZERO;
    end else if (d < radix_value(num_radix)) begin
      take_digit(d);
      num_phase = NUM_DIGITS;
    end else begin
      num_phase = NUM_STOP;
    end
  endtask

  task automatic convert_char(input logic [7:0] c);
    int unsigned d;
    d = digit_value(c);
    case (num_phase)
      NUM_SKIP: begin
        if (is_blank(c)) begin
        end else if (c == PLUS_CHAR) begin
          num_phase = NUM_SIGNED;
        end else if (c == MINUS_CHAR) begin
          negative  = 1'b1;
          num_phase = NUM_SIGNED;
        end else begin
          first_digit(c);
        end
      end
      NUM_SIGNED: first_digit(c);
      NUM_ZERO: begin
        if (c == X_LO_CHAR || c == X_UP_CHAR) begin
          num_radix = RADIX_HEX;
          num_phase = NUM_PREFIX;
        end else if (d < radix_value(num_radix)) begin
          take_digit(d);
          num_phase = NUM_DIGITS;
        end else begin
          num_phase = NUM_STOP;
        end
      end
      NUM_PREFIX: begin
        if (d < 16) begin
          take_digit(d);
          num_phase = NUM_DIGITS;
        end else begin
          num_phase = NUM_STOP;
        end
      end
      NUM_DIGITS: begin
        if (d < radix_value(num_radix)) take_digit(d);
        else num_phase = NUM_STOP;
      end
      default: begin
      end
    endcase
  endtask

  task automatic open_name();
    line_phase = LINE_NAME;
    name_pos   = '0;
    name_hits  = HITS_BOTH;
  endtask

  task automatic open_value();
    line_phase  = LINE_VALUE;
    value_begun = 1'b0;
    num_phase   = NUM_SKIP;
    num_radix   = (name_hits == HITS_PORT) ? RADIX_HEX : RADIX_DEC;
    negative    = 1'b0;
    accum       = '0;
    overflowed  = 1'b0;
  endtask

  task automatic match_name_char(input logic [7:0] c);
    if (!(name_pos < PORT_LEN && c == port_word[name_pos])) name_hits &= HITS_SPEED;
    if (!(name_pos < SPEED_LEN && c == speed_word[name_pos])) name_hits &= HITS_PORT;
    if (name_pos < POS_MAX) name_pos++;
  endtask

  task automatic close_option();
    result_t     r;
    logic [63:0] v;
    if (name_hits == HITS_PORT || name_hits == HITS_SPEED) begin
      if (overflowed) v = ALL_ONES;
      else if (negative) v = (64'd0 - accum) & ALL_ONES;
      else v = accum;
      r.option_id    = (name_hits == HITS_SPEED) ? SPEED_ID : PORT_ID;
      r.option_value = v[31:0];
      pending_options.push_back(r);
    end
  endtask

  task automatic parse_char(input logic [7:0] c);
    if (c == END_CHAR) begin
      if (line_phase == LINE_VALUE && value_begun) close_option();
      reset_parser();
    end else begin
      case (line_phase)
        LINE_BLANK: begin
          if (c == BS_CHAR) open_name();
          else if (c != SP_CHAR) line_phase = LINE_AT_BS;
        end
        LINE_AT_BS: begin
          if (c == BS_CHAR) open_name();
          else if (c == SP_CHAR) line_phase = LINE_BLANK;
        end
        LINE_NAME: begin
          if (c == EQ_CHAR) begin
            if (name_pos != PORT_LEN) name_hits &= HITS_SPEED;
            if (name_pos != SPEED_LEN) name_hits &= HITS_PORT;
            open_value();
          end else if (c == SP_CHAR) begin
            line_phase = LINE_BLANK;
          end else begin
            match_name_char(c);
          end
        end
        LINE_VALUE: begin
          if (!value_begun) begin
            convert_char(c);
            value_begun = 1'b1;
          end else if (c == SP_CHAR || c == BS_CHAR) begin
            close_option();
            if (c == SP_CHAR) line_phase = LINE_BLANK;
            else open_name();
          end else begin
            convert_char(c);
          end
        end
        default: begin
          line_phase = LINE_IMAGE;
          if (c == SP_CHAR) line_phase = LINE_BLANK;
          else if (c == BS_CHAR) open_name();
        end
      endcase
    end
  endtask

  // Handshake helpers.
  function automatic int unsigned draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Called and returns just after a falling edge; push stays high between items without a gap.
  task automatic send_char(input logic [7:0] c);
    int unsigned gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    char_code_i = c;
    push        = 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    parse_char(c);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
  endtask

  task automatic check_result();
    result_t want;
    if (pending_options.size() == 0) begin
      report_mismatch("unexpected result", option_value_o, '0);
    end else begin
      want = pending_options.pop_front();
      if (option_id_o !== want.option_id)
        report_mismatch("option_id", 32'(option_id_o), 32'(want.option_id));
      if (option_value_o !== want.option_value)
        report_mismatch("option_value", option_value_o, want.option_value);
    end
  endtask

  initial begin
    int unsigned wait_left;
    pop       = 1'b0;
    wait_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        check_result();
        wait_left = draw_wait(pop_calm);
      end
      @(negedge clk_i);
      if (wait_left > 0) begin
        pop = 1'b0;
        wait_left--;
      end else begin
        pop = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Random stimulus.
  function automatic logic [7:0] random_letter();
    return 8'(8'h61 + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] random_digit();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 10) return 8'(8'h30 + r);
    if (r < 13) return 8'(8'h61 + (r - 10) * 2);
    if (r < 16) return 8'(8'h41 + (r - 13) * 2 + 1);
    if (r == 16) return 8'h67;
    return 8'(8'h21 + $urandom_range(0, 93));
  endfunction

  task automatic send_random_value();
    int unsigned n;
    int          i;
    if ($urandom_range(0, 9) == 0) return;
    if ($urandom_range(0, 7) == 0) send_char(8'(8'h09 + $urandom_range(0, 4)));
    case ($urandom_range(0, 5))
      0: send_char(PLUS_CHAR);
      1: send_char(MINUS_CHAR);
      default: begin
      end
    endcase
    case ($urandom_range(0, 5))
      0: send_text("0x");
      1: send_text("0X");
      2: send_char(8'h30);
      default: begin
      end
    endcase
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 30) : $urandom_range(0, 9);
    for (i = 0; i < n; i++) send_char(random_digit());
  endtask

  task automatic send_random_option();
    int unsigned pick;
    int unsigned n;
    int          i;
    string       word;
    pick = $urandom_range(0, 15);
    word = pick[0] ? port_word : speed_word;
    if (pick < 6) begin
      send_text(port_word);
    end else if (pick < 12) begin
      send_text(speed_word);
    end else if (pick == 12) begin
      n = $urandom_range(0, word.len() - 1);
      for (i = 0; i < n; i++) send_char(word[i]);
    end else if (pick == 13) begin
      send_text(word);
      send_char(random_letter());
    end else if (pick == 14) begin
      send_text(word);
      n = $urandom_range(16, 30);
      for (i = 0; i < n; i++) send_char(random_letter());
    end else begin
      n = $urandom_range(0, word.len() - 1);
      for (i = 0; i < word.len(); i++) send_char((i == n) ? random_letter() : word[i]);
    end
    if ($urandom_range(0, 9) != 0) begin
      send_char(EQ_CHAR);
      send_random_value();
    end
  endtask

  task automatic send_random_line();
    int unsigned opts;
    int unsigned n;
    int          i;
    int          k;
    bit          at_name;
    send_calm = ($urandom_range(0, 3) == 0);
    pop_calm  = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(4, 24);
      for (i = 0; i < n; i++) send_char(8'($urandom_range(0, 255)));
      send_char(END_CHAR);
      return;
    end
    n = $urandom_range(0, 6);
    for (i = 0; i < n; i++) send_char(8'(8'h21 + $urandom_range(0, 93)));
    at_name = 1'b0;
    opts    = $urandom_range(1, 4);
    for (k = 0; k < opts; k++) begin
      if (!at_name) begin
        if ($urandom_range(0, 4) == 0) begin
          send_char(SP_CHAR);
          send_char(random_letter());
        end
        repeat ($urandom_range(0, 2)) send_char(SP_CHAR);
        send_char(BS_CHAR);
      end
      send_random_option();
      case ($urandom_range(0, 5))
        0: begin
          send_char(END_CHAR);
          return;
        end
        1: begin
          at_name = 1'b1;
          send_char(BS_CHAR);
        end
        default: begin
          at_name = 1'b0;
          send_char(SP_CHAR);
        end
      endcase
    end
    send_char(END_CHAR);
  endtask

  // Tests.
  task automatic test_line_edges();
    send_char(8'hFF);
    send_char(8'h80);
    send_char(SP_CHAR);
    send_text("\\debugport=");
    send_char(END_CHAR);
  endtask

  task automatic test_port_values();
    send_text("\\debugport=-0xFFFFFFFF");
    send_char(END_CHAR);
  endtask

  task automatic test_speed_values();
    send_text("\\debugspeed=077\\debugspeed=4294967296 ");
    send_char(END_CHAR);
  endtask

  task automatic test_name_matching();
    send_text("x \\debugspeeds=1 \\debugpor=2");
    send_char(END_CHAR);
  endtask

  task automatic test_random_lines();
    while (items_sent < ITEM_TARGET) send_random_line();
  endtask

  initial begin
    rst_ni      = 1'b0;
    push        = 1'b0;
    char_code_i = END_CHAR;
    items_sent  = 0;
    cycle_count = 0;
    errors      = 0;
    send_calm   = 1'b0;
    pop_calm    = 1'b0;
    reset_parser();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_line_edges();
    test_port_values();
    test_speed_values();
    test_name_matching();
    test_random_lines();

    push = 1'b0;
    while (pending_options.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
